/* rtl/tcq_pkg.sv */
// Shared types and constants for the two-class order-preserving ticket queue.
// Used by the control module and the top level; no dependencies.
package tcq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int TICKET_BITS_DEFAULT = 16;

   localparam int REQ_TICKET_BITS = 16;
   localparam int RSP_FILL_BITS = 5;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

/* rtl/tcq_mem.sv */
// Entry store of the ticket queue: simple dual-port memory with a registered read.
// Standalone; no package dependency.
module tcq_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tcq_ctrl.sv */
// Sequencer of the ticket queue: appends, searches for the oldest entry of the
// wanted class and compacts the memory behind it. Depends on tcq_pkg.
module tcq_ctrl #(
   parameter int DEPTH = 16,
   parameter int TICKET_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic [tcq_pkg::REQ_TICKET_BITS-1:0]  req_ticket_in,
   input  logic                                 req_class_in,
   input  logic                                 req_wanted_class,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [tcq_pkg::REQ_TICKET_BITS-1:0]  rsp_ticket_out,
   output logic                                 rsp_class_out,
   output logic [tcq_pkg::RSP_FILL_BITS-1:0]    rsp_fill_level,
   output logic                                 mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]             mem_wr_addr,
   output logic [TICKET_BITS:0]                 mem_wr_data,
   output logic [$clog2(DEPTH)-1:0]             mem_rd_addr,
   input  logic [TICKET_BITS:0]                 mem_rd_data
);
   import tcq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type              state_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          pend_idx_ff;
   logic                   found_ff;
   logic                   want_ff;
   logic [TICKET_BITS-1:0] tout_ff;
   logic                   cout_ff;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [TICKET_BITS-1:0] rsp_ticket_ff;
   logic                   rsp_class_ff;

   logic                   is_last;
   logic                   is_match;
   logic                   capture;
   logic                   restart;
   logic [TICKET_BITS-1:0] take_ticket;
   logic                   take_class;
   logic [CW-1:0]          count_less_one;

   assign count_less_one = count_ff - CW'(1);
   assign is_last  = (pend_idx_ff == count_less_one);
   assign is_match = (mem_rd_data[TICKET_BITS] == want_ff);
   // The head is always kept so it can be taken when no entry of the class exists.
   assign capture  = !found_ff && (is_match || pend_idx_ff == '0);
   // No match anywhere: take the head and run a shift pass from entry one.
   assign restart  = !found_ff && !is_match && is_last && (count_ff != CW'(1));
   assign take_ticket = capture ? mem_rd_data[TICKET_BITS-1:0] : tout_ff;
   assign take_class  = capture ? mem_rd_data[TICKET_BITS] : cout_ff;

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = AW'(count_ff);
      mem_wr_data = {req_class_in, TICKET_BITS'(req_ticket_in)};
      mem_rd_addr = '0;
      unique case (state_ff)
         S_IDLE: begin
            mem_wr_en = start && (req_opcode == OP_ADD) && (count_ff != CW'(DEPTH));
         end
         S_SCAN: begin
            mem_rd_addr = restart ? AW'(1) : AW'(pend_idx_ff + CW'(1));
            if (found_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = AW'(pend_idx_ff - CW'(1));
               mem_wr_data = mem_rd_data;
            end
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  rsp_ticket_ff <= '0;
                  rsp_class_ff  <= 1'b0;
                  if (req_opcode == OP_ADD) begin
                     rsp_valid_ff <= 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_ff <= ST_FULL;
                     end else begin
                        rsp_status_ff <= ST_DONE;
                        count_ff      <= count_ff + CW'(1);
                     end
                  end else if (count_ff == '0) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= ST_EMPTY;
                  end else begin
                     state_ff    <= S_SCAN;
                     pend_idx_ff <= '0;
                     found_ff    <= 1'b0;
                     want_ff     <= req_wanted_class;
                  end
               end
            end
            S_SCAN: begin
               if (capture) begin
                  tout_ff <= mem_rd_data[TICKET_BITS-1:0];
                  cout_ff <= mem_rd_data[TICKET_BITS];
               end
               if (!found_ff && is_match) begin
                  found_ff <= 1'b1;
               end
               if (restart) begin
                  found_ff    <= 1'b1;
                  pend_idx_ff <= CW'(1);
               end else if (is_last) begin
                  state_ff      <= S_IDLE;
                  found_ff      <= 1'b0;
                  count_ff      <= count_less_one;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_DONE;
                  rsp_ticket_ff <= take_ticket;
                  rsp_class_ff  <= take_class;
               end else begin
                  pend_idx_ff <= pend_idx_ff + CW'(1);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_ticket_out = REQ_TICKET_BITS'(rsp_ticket_ff);
   assign rsp_class_out  = rsp_class_ff;
   assign rsp_fill_level = RSP_FILL_BITS'(count_ff);

endmodule

/* rtl/two_class_order_preserving_queue.sv */
// Add: result strobe on the next cycle; busy never rises.
// Remove: held entries are read one at a time through the single read port. The oldest entry
// of the wanted class is taken, or the head when none exists, and the entries behind it shift.
// Full or empty: result on the next cycle. The receiver cannot stall.
// Synchronous reset empties the queue; memory contents are not cleared.
// Top level of the ticket queue; depends on tcq_pkg, tcq_mem and tcq_ctrl.
module two_class_order_preserving_queue #(
   parameter int DEPTH = tcq_pkg::DEPTH_DEFAULT,
   parameter int TICKET_BITS = tcq_pkg::TICKET_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic [tcq_pkg::REQ_TICKET_BITS-1:0]  req_ticket_in,
   input  logic                                 req_class_in,
   input  logic                                 req_wanted_class,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [tcq_pkg::REQ_TICKET_BITS-1:0]  rsp_ticket_out,
   output logic                                 rsp_class_out,
   output logic [tcq_pkg::RSP_FILL_BITS-1:0]    rsp_fill_level
);
   import tcq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [TICKET_BITS:0] mem_wr_data;
   logic [AW-1:0]        mem_rd_addr;
   logic [TICKET_BITS:0] mem_rd_data;

   tcq_ctrl #(
      .DEPTH       (DEPTH),
      .TICKET_BITS (TICKET_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_ticket_in    (req_ticket_in),
      .req_class_in     (req_class_in),
      .req_wanted_class (req_wanted_class),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_ticket_out   (rsp_ticket_out),
      .rsp_class_out    (rsp_class_out),
      .rsp_fill_level   (rsp_fill_level),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

   tcq_mem #(
      .DEPTH (DEPTH),
      .WIDTH (TICKET_BITS + 1)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
